// ===== sv/adz_pkg.sv =====
// shared types and constants for the axis deadzone scaler
`default_nettype none

package adz_pkg;

	localparam int SMP_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int NUM_W  = 35;
	localparam int DEN_W  = 16;
	localparam int CNT_W  = 6;
	localparam int OUT_TDATA_W = 40;

	localparam logic [IDX_W-1:0] REG_INPUT_LOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_INPUT_HIGH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 3'd2;
	localparam logic [IDX_W-1:0] REG_OUTPUT_LOW    = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUTPUT_HIGH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_NEGATE_INPUT  = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIRROR_OUTPUT = 3'd6;

	localparam logic signed [15:0] RST_INPUT_LOW   = 16'sd0;
	localparam logic signed [15:0] RST_INPUT_HIGH  = 16'sd4095;
	localparam logic [14:0]        RST_DEAD_BAND   = 15'd0;
	localparam logic signed [15:0] RST_OUTPUT_LOW  = 16'sd0;
	localparam logic signed [15:0] RST_OUTPUT_HIGH = 16'sd1023;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MID,
		S_CMP,
		S_SUB,
		S_MUL,
		S_MAG,
		S_GO,
		S_DIV,
		S_POST1,
		S_POST2,
		S_POST3
	} state_t;

endpackage

`default_nettype wire

// ===== sv/analog_axis_deadzone_scaler.sv =====
// top level: axis deadzone removal and linear scaling with a serial divider
//
// usage: raw samples enter on the s_ stream (s_tdata[15:0] = raw_sample),
// results leave on the m_ stream. registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block
// is idle, which the block itself does not enforce. unknown indexes are ignored.
// each item walks a short sequencer: midpoint and ranges, deadzone test,
// offset, one 19x16 multiply, magnitude, then a 35-step restoring divider,
// then sign, clamp and mirror. s_tready is high only while the sequencer is
// idle, so a new item is taken only once the last one has left the sequencer.
// the result sits in an output register; the next item may be accepted
// while it waits, and if the receiver still stalls when the next result is
// done, the sequencer holds in its last step until the output register frees.
// reset clears the registers to their defaults, the previous value to zero
// and drops the output valid.
`default_nettype none

module analog_axis_deadzone_scaler (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [adz_pkg::SMP_W-1:0]       s_tdata,   // raw_sample
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [adz_pkg::OUT_TDATA_W-1:0]      m_tdata,   // axis_value, raw_seen, zero pad
	output logic [0:0]                           m_tuser,   // value_changed
	input  wire logic                            cfg_we,
	input  wire logic [adz_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [adz_pkg::CFG_W-1:0]       cfg_wdata
);
	import adz_pkg::*;

	logic signed [15:0] input_low_q, input_high_q, output_low_q, output_high_q;
	logic [14:0]        dead_band_q;
	logic               negate_q, mirror_q;

	state_t state_q, state_d;

	logic signed [16:0] raw_q;
	logic signed [15:0] mid_q, omid_q, in_range_q, in_min_q, out_range_q;
	logic               dead_q;
	logic signed [17:0] shifted_q;
	logic signed [18:0] a_q;
	logic signed [34:0] prod_q;
	logic [NUM_W-1:0]   nmag_q;
	logic [DEN_W-1:0]   dmag_q;
	logic               qneg_q, zden_q;
	logic signed [36:0] val_q;
	logic signed [15:0] clamp_q;
	logic [15:0]        prev_q;
	logic               out_valid_q;
	logic [15:0]        out_value_q;
	logic signed [16:0] out_seen_q;
	logic               out_changed_q;

	logic               accept, load, div_start, div_done;
	logic [NUM_W-1:0]   div_quo;
	logic signed [16:0] smp;
	logic signed [17:0] sum_in, sum_out;
	logic [17:0]        rnd_in, rnd_out;
	logic signed [17:0] diff, dz18;
	logic [17:0]        absd;
	logic [34:0]        pmag;
	logic [15:0]        dmag;
	logic signed [36:0] qext, qs;
	logic [15:0]        res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_low_q   <= RST_INPUT_LOW;
			input_high_q  <= RST_INPUT_HIGH;
			dead_band_q   <= RST_DEAD_BAND;
			output_low_q  <= RST_OUTPUT_LOW;
			output_high_q <= RST_OUTPUT_HIGH;
			negate_q      <= 1'b0;
			mirror_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_LOW:     input_low_q   <= cfg_wdata;
				REG_INPUT_HIGH:    input_high_q  <= cfg_wdata;
				REG_DEAD_BAND:     dead_band_q   <= cfg_wdata[14:0];
				REG_OUTPUT_LOW:    output_low_q  <= cfg_wdata;
				REG_OUTPUT_HIGH:   output_high_q <= cfg_wdata;
				REG_NEGATE_INPUT:  negate_q      <= cfg_wdata[0];
				REG_MIRROR_OUTPUT: mirror_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = S_MID;
			end
			S_MID:   state_d = S_CMP;
			S_CMP:   state_d = S_SUB;
			S_SUB:   state_d = S_MUL;
			S_MUL:   state_d = S_MAG;
			S_MAG:   state_d = S_GO;
			S_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV:   if (div_done) state_d = S_POST1;
			S_POST1: state_d = S_POST2;
			S_POST2: state_d = S_POST3;
			S_POST3: begin
				if (!out_valid_q || m_tready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// datapath arithmetic
	assign smp     = {s_tdata[15], s_tdata};
	assign sum_in  = 18'(input_low_q) + 18'(input_high_q);
	assign rnd_in  = sum_in + {17'd0, ~sum_in[17]};
	assign sum_out = 18'(output_low_q) + 18'(output_high_q);
	assign rnd_out = sum_out + {17'd0, ~sum_out[17]};
	assign dz18    = {3'd0, dead_band_q};
	assign diff    = 18'(raw_q) - 18'(mid_q);
	assign absd    = diff[17] ? -diff : diff;
	assign pmag    = prod_q[34] ? -prod_q : prod_q;
	assign dmag    = in_range_q[15] ? -in_range_q : in_range_q;
	assign qext    = {2'b00, div_quo};
	assign qs      = zden_q ? 37'sd0 : (qneg_q ? -qext : qext);
	assign res     = mirror_q ? output_high_q - clamp_q : clamp_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) raw_q <= negate_q ? -smp : smp;
			S_MID: begin
				mid_q       <= rnd_in[16:1];
				omid_q      <= rnd_out[16:1];
				in_range_q  <= input_high_q - input_low_q - {dead_band_q, 1'b0};
				in_min_q    <= input_low_q + {1'b0, dead_band_q};
				out_range_q <= output_high_q - output_low_q;
			end
			S_CMP: begin
				dead_q    <= (dead_band_q != 15'd0) && (absd < {3'd0, dead_band_q});
				shifted_q <= diff[17] ? 18'(raw_q) + dz18 : 18'(raw_q) - dz18;
			end
			S_SUB: a_q <= 19'(shifted_q) - 19'(in_min_q);
			S_MUL: prod_q <= 35'(a_q) * 35'(out_range_q);
			S_MAG: begin
				nmag_q <= pmag + {20'd0, dmag[15:1]};
				dmag_q <= dmag;
				qneg_q <= prod_q[34] ^ in_range_q[15];
				zden_q <= in_range_q == 16'sd0;
			end
			S_POST1: val_q <= dead_q ? 37'(omid_q) : qs + 37'(output_low_q);
			S_POST2: begin
				if (val_q < 37'(output_low_q)) clamp_q <= output_low_q;
				else if (val_q > 37'(output_high_q)) clamp_q <= output_high_q;
				else clamp_q <= val_q[15:0];
			end
			default: ;
		endcase
	end

	adz_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (nmag_q),
		.den    (dmag_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	// output register and previous value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_q      <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			prev_q      <= res;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q   <= res;
			out_changed_q <= res != prev_q;
			out_seen_q    <= raw_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {7'd0, out_seen_q, out_value_q};
	assign m_tuser[0] = out_changed_q;

endmodule

`default_nettype wire

// ===== sv/adz_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module adz_divider (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [adz_pkg::NUM_W-1:0] num,
	input  wire logic [adz_pkg::DEN_W-1:0] den,
	output logic      [adz_pkg::NUM_W-1:0] quo,
	output logic                           done
);
	import adz_pkg::*;

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   sh;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign sh    = {rem_q, quo_q[NUM_W-1]};
	assign ge    = sh >= {1'b0, den_q};
	assign trial = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? trial[DEN_W-1:0] : sh[DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== sv/adz_checker.sv =====
// port-level checker for the axis deadzone scaler and its bind
`default_nettype none

module adz_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [adz_pkg::SMP_W-1:0]       s_tdata,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [adz_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [0:0]                      m_tuser,
	input wire logic                            cfg_we,
	input wire logic [adz_pkg::IDX_W-1:0]       cfg_index,
	input wire logic [adz_pkg::CFG_W-1:0]       cfg_wdata
);
	import adz_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input taken while busy");

	// a new result is loaded only at the end of the sequence
	a_load_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a finished item");

	// padding above raw_seen stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:33] == '0)
		else $error("nonzero padding in result");

endmodule

bind analog_axis_deadzone_scaler adz_checker u_adz_checker (.*);

`default_nettype wire

// ===== tb/axis_scale_checker.sv =====
// checker for the axis deadzone scaler: predicts each result and compares it with the output
`timescale 1ns / 1ps

module axis_scale_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	input  wire logic                            s_tready,
	input  wire logic [adz_pkg::SMP_W-1:0]       s_tdata,   // raw_sample
	input  wire logic                            m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic [adz_pkg::OUT_TDATA_W-1:0] m_tdata,   // axis_value, raw_seen, zero pad
	input  wire logic [0:0]                      m_tuser,   // value_changed
	input  wire logic                            cfg_we,
	input  wire logic [adz_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [adz_pkg::CFG_W-1:0]       cfg_wdata,
	output int                                   fail_count,
	output int                                   pending
);
	import adz_pkg::*;

	typedef struct {
		logic signed [15:0] axis_value;
		logic               value_changed;
		logic signed [16:0] raw_seen;
	} axis_result_t;

	axis_result_t expected_results[$];

	logic signed [15:0] in_lo_r, in_hi_r, out_lo_r, out_hi_r;
	logic [14:0]        dead_r;
	logic               negate_r, mirror_r;
	logic [15:0]        last_value;

	function automatic longint round_half_away(longint n, longint d);
		if (d == 0)
			return 0;
		if ((n < 0) != (d < 0))
			return (n - d / 2) / d;
		return (n + d / 2) / d;
	endfunction

	function automatic longint wrap16(longint v);
		logic signed [15:0] t;
		t = v[15:0];
		return longint'(t);
	endfunction

	function automatic axis_result_t scale_axis(logic signed [15:0] sample);
		longint lo, hi, olo, ohi, dz, raw, mid, diff, span, base, gain, val;
		axis_result_t r;
		lo = longint'(in_lo_r);
		hi = longint'(in_hi_r);
		olo = longint'(out_lo_r);
		ohi = longint'(out_hi_r);
		dz = longint'(dead_r);
		raw = longint'(sample);
		if (negate_r)
			raw = -raw;
		r.raw_seen = raw[16:0];
		mid = round_half_away(lo + hi, 2);
		diff = raw - mid;
		if (diff < 0)
			diff = -diff;
		if (dz > 0 && diff < dz) begin
			val = round_half_away(ohi + olo, 2);
		end else begin
			span = wrap16(hi - lo - 2 * dz);
			base = wrap16(lo + dz);
			gain = wrap16(ohi - olo);
			if (raw < mid)
				raw = raw + dz;
			else
				raw = raw - dz;
			val = round_half_away((raw - base) * gain, span) + olo;
		end
		if (val < olo)
			val = olo;
		else if (val > ohi)
			val = ohi;
		if (mirror_r)
			val = ohi - val;
		r.axis_value = val[15:0];
		r.value_changed = (val[15:0] != last_value);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		axis_result_t want, got;
		if (!arst_n) begin
			in_lo_r = RST_INPUT_LOW;
			in_hi_r = RST_INPUT_HIGH;
			dead_r = RST_DEAD_BAND;
			out_lo_r = RST_OUTPUT_LOW;
			out_hi_r = RST_OUTPUT_HIGH;
			negate_r = 1'b0;
			mirror_r = 1'b0;
			last_value = '0;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.axis_value = m_tdata[15:0];
				got.raw_seen = m_tdata[32:16];
				got.value_changed = m_tuser[0];
				if (expected_results.size() == 0) begin
					$error("result with no item pending: axis_value %0d", got.axis_value);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.axis_value !== want.axis_value) begin
						$error("axis_value: expected %0d, got %0d",
							want.axis_value, got.axis_value);
						fail_count++;
					end
					if (got.value_changed !== want.value_changed) begin
						$error("value_changed: expected %0d, got %0d",
							want.value_changed, got.value_changed);
						fail_count++;
					end
					if (got.raw_seen !== want.raw_seen) begin
						$error("raw_seen: expected %0d, got %0d",
							want.raw_seen, got.raw_seen);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = scale_axis(s_tdata);
				last_value = want.axis_value;
				expected_results.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_INPUT_LOW:     in_lo_r = cfg_wdata;
					REG_INPUT_HIGH:    in_hi_r = cfg_wdata;
					REG_DEAD_BAND:     dead_r = cfg_wdata[14:0];
					REG_OUTPUT_LOW:    out_lo_r = cfg_wdata;
					REG_OUTPUT_HIGH:   out_hi_r = cfg_wdata;
					REG_NEGATE_INPUT:  negate_r = cfg_wdata[0];
					REG_MIRROR_OUTPUT: mirror_r = cfg_wdata[0];
					default: ;
				endcase
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== tb/tb.sv =====
// testbench top for the axis deadzone scaler: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module tb;
	import adz_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [15:0] in_lo;
		logic signed [15:0] in_hi;
		logic [14:0]        dead;
		logic signed [15:0] out_lo;
		logic signed [15:0] out_hi;
		bit                 neg;
		bit                 mir;
	} scaler_setting_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [SMP_W-1:0]       s_tdata;        // raw_sample
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;        // axis_value, raw_seen, zero pad
	logic [0:0]             m_tuser;        // value_changed
	logic                   cfg_we;
	logic [IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	scaler_setting_t cur_setting;
	logic [15:0] last_sample;

	analog_axis_deadzone_scaler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	axis_scale_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	task automatic apply_setting(input scaler_setting_t s);
		logic [15:0] junk;
		junk = 16'($urandom);
		write_reg(REG_INPUT_LOW, s.in_lo);
		write_reg(REG_INPUT_HIGH, s.in_hi);
		write_reg(REG_DEAD_BAND, {junk[15], s.dead});
		write_reg(REG_OUTPUT_LOW, s.out_lo);
		write_reg(REG_OUTPUT_HIGH, s.out_hi);
		write_reg(REG_NEGATE_INPUT, {junk[15:1], s.neg});
		write_reg(REG_MIRROR_OUTPUT, {junk[14:0], s.mir});
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
		cur_setting = s;
	endtask

	task automatic push_sample(input logic [15:0] v);
		bit ready_now;
		if (send_idle_pct != 0 && $urandom_range(7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(60, 1)) @(negedge clk);
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do begin
			ready_now = s_tready;
			@(negedge clk);
		end while (!ready_now);
	endtask

	// hold the sender until every result is back, then let the sequencer settle
	task automatic drain;
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic scaler_setting_t random_setting();
		scaler_setting_t s;
		int lo, hi, span, ol, oh, k;
		k = $urandom_range(9);
		if (k < 6) begin
			lo = $urandom_range(1500) - 500;
			hi = lo + $urandom_range(8000, 64);
		end else if (k < 8) begin
			lo = -32768 + $urandom_range(100);
			hi = 32767 - $urandom_range(100);
		end else begin
			lo = $urandom_range(65535) - 32768;
			hi = $urandom_range(65535) - 32768;
		end
		span = (hi > lo) ? hi - lo : lo - hi;
		s.in_lo = 16'(lo);
		s.in_hi = 16'(hi);
		k = $urandom_range(9);
		if (k < 4)
			s.dead = '0;
		else if (k < 8)
			s.dead = 15'($urandom_range(span / 4 + 1, 1));
		else
			s.dead = 15'($urandom_range(32767));
		k = $urandom_range(9);
		if (k < 6) begin
			ol = $urandom_range(2000) - 1000;
			oh = ol + $urandom_range(4000, 1);
		end else if (k == 6) begin
			ol = $urandom_range(65535) - 32768;
			oh = ol;
		end else if (k < 9) begin
			ol = $urandom_range(65535) - 32768;
			oh = $urandom_range(65535) - 32768;
		end else begin
			oh = $urandom_range(2000) - 1000;
			ol = oh + $urandom_range(4000, 1);
		end
		s.out_lo = 16'(ol);
		s.out_hi = 16'(oh);
		s.neg = 1'($urandom_range(1));
		s.mir = 1'($urandom_range(1));
		return s;
	endfunction

	// mostly samples inside the calibrated span and around the deadzone edges
	function automatic logic [15:0] pick_sample();
		int lo, hi, a, b, mid, v, k;
		lo = int'(cur_setting.in_lo);
		hi = int'(cur_setting.in_hi);
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		mid = (lo + hi) / 2;
		k = $urandom_range(99);
		if (k < 5)
			return last_sample;
		if (k < 20) begin
			v = $urandom;
		end else if (k < 40) begin
			v = cur_setting.dead + $urandom_range(4) - 2;
			if ($urandom_range(1))
				v = -v;
			v = mid + v;
		end else begin
			v = a - 16 + $urandom_range(b - a + 32);
		end
		if (cur_setting.neg && k >= 20)
			v = -v;
		last_sample = v[15:0];
		return v[15:0];
	endfunction

	initial begin
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		scaler_setting_t s;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INPUT_LOW;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		last_sample = '0;
		cur_setting = '{RST_INPUT_LOW, RST_INPUT_HIGH, RST_DEAD_BAND,
			RST_OUTPUT_LOW, RST_OUTPUT_HIGH, 1'b0, 1'b0};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults
		push_sample(16'd0);
		push_sample(16'd4095);
		push_sample(16'd2048);
		drain;

		// deadzone edges around the midpoint
		apply_setting('{16'sd0, 16'sd4095, 15'd200, 16'sd0, 16'sd1023, 1'b0, 1'b0});
		push_sample(16'd2048);
		push_sample(16'd2247);
		push_sample(16'd2248);
		push_sample(16'd1848);
		push_sample(16'd1847);
		push_sample(16'h8000);
		push_sample(16'h7fff);
		drain;

		// full-width ranges that wrap, negation of the most negative sample, mirror
		apply_setting('{16'sh8000, 16'sh7fff, 15'd0, 16'sh8000, 16'sh7fff, 1'b1, 1'b1});
		push_sample(16'h8000);
		push_sample(16'h7fff);
		push_sample(16'h0000);
		push_sample(16'hffff);
		drain;

		// zero divisor with inverted output bounds
		apply_setting('{16'sd100, 16'sd100, 15'd0, 16'sd500, -16'sd500, 1'b0, 1'b0});
		push_sample(16'd100);
		push_sample(-16'sd7);
		push_sample(16'd9);
		drain;

		// widest deadzone and a mirror that overflows
		apply_setting('{16'sd0, 16'sd1000, 15'h7fff, 16'sh7fff, 16'sh8000, 1'b0, 1'b1});
		push_sample(16'd500);
		push_sample(16'd0);
		drain;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct = 10;
					recv_stall_pct = 10;
				end
			endcase
			for (int n = 0; n < 4; n++) begin
				s = random_setting();
				apply_setting(s);
				repeat (115) push_sample(pick_sample());
				drain;
			end
		end

		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== analog_axis_deadzone_scaler.f =====
sv/adz_pkg.sv
sv/adz_divider.sv
sv/analog_axis_deadzone_scaler.sv
sv/adz_checker.sv
tb/axis_scale_checker.sv
tb/tb.sv
